/* rtl/core/ssad_pkg.sv */
// Shared types, constants and the arctangent table for the strip survey
// alignment delta unit. No dependencies; every other file imports this package.
`default_nettype none
package ssad_pkg;

  // Default parameter values.
  localparam int DEF_STRIPS_X         = 64;
  localparam int DEF_STRIPS_Z         = 16;
  localparam int DEF_ANGLE_ITERATIONS = 16;
  localparam int MAX_ITERATIONS       = 24;

  // Datapath widths: CORDIC vector width and angle accumulator width.
  localparam int CW = 58;
  localparam int ZW = 28;

  // Configuration register indexes.
  localparam logic [7:0] REG_STRIP_HALF_X = 8'd0;
  localparam logic [7:0] REG_STRIP_HALF_Z = 8'd1;
  localparam logic [7:0] REG_CELL_HALF_X  = 8'd2;
  localparam logic [7:0] REG_CELL_HALF_Z  = 8'd3;

  localparam logic [15:0] HALF_RESET = 16'd1024;

  // Angles in units of 2^-20 degree.
  localparam logic signed [ZW-1:0] DEG90 = 28'sd94371840;

  // atan(2^-i) in units of 2^-20 degree.
  localparam logic [26:0] ATAN_TAB [MAX_ITERATIONS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
    27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342,
    27'd58671, 27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833,
    27'd917, 27'd458, 27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
  };

  // One CORDIC lane. A forced lane already holds its final angle in z.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 forced;
    logic                 undef;
  } lane_t;

  // Midpoint shifts that ride along the CORDIC stages.
  typedef struct packed {
    logic signed [24:0] x_shift;
    logic signed [24:0] z_shift;
  } shift_t;

endpackage
`default_nettype wire

/* rtl/core/ssad_front.sv */
// Front end: index clamping, ideal geometry, midpoint shifts and CORDIC setup.
// Two register stages. Depends on ssad_pkg.
`default_nettype none
module ssad_front #(
  parameter int STRIPS_X = ssad_pkg::DEF_STRIPS_X,
  parameter int STRIPS_Z = ssad_pkg::DEF_STRIPS_Z
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [5:0]         strip_col,
  input  wire logic [3:0]         strip_row,
  input  wire logic signed [23:0] real_x1,
  input  wire logic signed [23:0] real_z1,
  input  wire logic signed [23:0] real_x2,
  input  wire logic signed [23:0] real_z2,
  input  wire logic [15:0]        strip_half_x,
  input  wire logic [15:0]        strip_half_z,
  input  wire logic [15:0]        cell_half_x,
  input  wire logic [15:0]        cell_half_z,
  output logic                    out_valid,
  output ssad_pkg::lane_t         lane_real,
  output ssad_pkg::lane_t         lane_ideal,
  output ssad_pkg::shift_t        shifts
);
  import ssad_pkg::*;

  localparam logic signed [26:0] SHIFT_MAX = 27'sd16777215;
  localparam logic signed [26:0] SHIFT_MIN = -27'sd16777216;

  // Stage 1 registers.
  logic               s1_valid;
  logic signed [24:0] s1_sum_x;
  logic signed [24:0] s1_sum_z;
  logic signed [24:0] s1_dx;
  logic signed [24:0] s1_dz;
  logic [22:0]        s1_ix1;
  logic [20:0]        s1_iz1;

  logic [5:0]  col_c;
  logic [3:0]  row_c;
  logic [21:0] prod_x;
  logic [19:0] prod_z;

  // Stage 2 logic.
  logic [23:0]        ideal_mx;
  logic [21:0]        ideal_mz;
  logic signed [26:0] xs_full;
  logic signed [26:0] zs_full;
  logic [19:0]        ideal_dx;
  logic [16:0]        ideal_dz;
  shift_t             shifts_next;
  lane_t              lane_real_next;
  lane_t              lane_ideal_next;

  // Builds a CORDIC lane from a span; vertical and empty spans are settled here.
  function automatic lane_t lane_prep(input logic signed [24:0] dx,
                                      input logic signed [24:0] dz);
    lane_t              l;
    logic signed [24:0] ax;
    logic signed [24:0] az;
    ax = dx[24] ? -dx : dx;
    az = dx[24] ? -dz : dz;
    l.x      = $signed({{(CW-55){ax[24]}}, ax, 30'b0});
    l.y      = $signed({{(CW-55){az[24]}}, az, 30'b0});
    l.forced = (dx == 25'sd0);
    l.undef  = (dx == 25'sd0) && (dz == 25'sd0);
    if (dx != 25'sd0 || dz == 25'sd0) begin
      l.z = '0;
    end else if (dz[24]) begin
      l.z = -DEG90;
    end else begin
      l.z = DEG90;
    end
    return l;
  endfunction

  function automatic logic signed [24:0] sat25(input logic signed [26:0] v);
    if (v > SHIFT_MAX) begin
      return 25'(SHIFT_MAX);
    end else if (v < SHIFT_MIN) begin
      return 25'(SHIFT_MIN);
    end
    return 25'(v);
  endfunction

  always_comb begin
    col_c  = (int'(strip_col) > STRIPS_X - 1) ? 6'(STRIPS_X - 1) : strip_col;
    row_c  = (int'(strip_row) > STRIPS_Z - 1) ? 4'(STRIPS_Z - 1) : strip_row;
    prod_x = 22'(col_c) * 22'(strip_half_x);
    prod_z = 20'(row_c) * 20'(strip_half_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_sum_x <= 25'(real_x1) + 25'(real_x2);
    s1_sum_z <= 25'(real_z1) + 25'(real_z2);
    s1_dx    <= 25'(real_x2) - 25'(real_x1);
    s1_dz    <= 25'(real_z2) - 25'(real_z1);
    s1_ix1   <= {prod_x, 1'b0};
    s1_iz1   <= {prod_z, 1'b0};
  end

  always_comb begin
    // Ideal midpoints: X1 + 7*cell_half_x and Z1 + cell_half_z.
    ideal_mx = 24'(s1_ix1) + 24'({cell_half_x, 3'b0} - {3'b0, cell_half_x});
    ideal_mz = 22'(s1_iz1) + 22'(cell_half_z);
    xs_full  = 27'(s1_sum_x >>> 1) - $signed({3'b0, ideal_mx});
    zs_full  = 27'(s1_sum_z >>> 1) - $signed({5'b0, ideal_mz});
    shifts_next.x_shift = sat25(xs_full);
    shifts_next.z_shift = sat25(zs_full);
    // Ideal spans: 14*cell_half_x and 2*cell_half_z.
    ideal_dx = {cell_half_x, 4'b0} - {3'b0, cell_half_x, 1'b0};
    ideal_dz = {cell_half_z, 1'b0};
    lane_real_next  = lane_prep(s1_dx, s1_dz);
    lane_ideal_next = lane_prep($signed({5'b0, ideal_dx}), $signed({8'b0, ideal_dz}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    shifts     <= shifts_next;
    lane_real  <= lane_real_next;
    lane_ideal <= lane_ideal_next;
  end

`ifndef NO_ASSERTIONS
  // An empty span must leave the CORDIC with a fixed angle of zero.
  a_undef_forced_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && lane_real.undef |-> lane_real.forced && lane_real.z == '0)
    else $error("empty real span did not force a zero angle");
`endif

endmodule
`default_nettype wire

/* rtl/core/ssad_cordic_stage.sv */
// One registered vectoring CORDIC iteration for the real and the ideal lane.
// Depends on ssad_pkg.
`default_nettype none
module ssad_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire ssad_pkg::lane_t  in_real,
  input  wire ssad_pkg::lane_t  in_ideal,
  input  wire ssad_pkg::shift_t in_shifts,
  output logic                  out_valid,
  output ssad_pkg::lane_t       out_real,
  output ssad_pkg::lane_t       out_ideal,
  output ssad_pkg::shift_t      out_shifts
);
  import ssad_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_STEP = $signed({1'b0, ATAN_TAB[STEP]});

  lane_t real_next;
  lane_t ideal_next;

  // Rotates toward y = 0; a forced lane passes through untouched.
  function automatic lane_t rotate(input lane_t l);
    lane_t                r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    r  = l;
    xs = l.x >>> STEP;
    ys = l.y >>> STEP;
    if (!l.forced) begin
      if (!l.y[CW-1]) begin
        r.x = l.x + ys;
        r.y = l.y - xs;
        r.z = l.z + ATAN_STEP;
      end else begin
        r.x = l.x - ys;
        r.y = l.y + xs;
        r.z = l.z - ATAN_STEP;
      end
    end
    return r;
  endfunction

  always_comb begin
    real_next  = rotate(in_real);
    ideal_next = rotate(in_ideal);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_real   <= real_next;
    out_ideal  <= ideal_next;
    out_shifts <= in_shifts;
  end

`ifndef NO_ASSERTIONS
  a_forced_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_real.forced |=> out_real.forced && out_real.z == $past(in_real.z))
    else $error("forced real angle changed inside a CORDIC stage");
`endif

endmodule
`default_nettype wire

/* rtl/core/ssad_back.sv */
// Back end: angle difference, rounding to 1/4096 degree, saturation and the
// registered result with its strobe. Depends on ssad_pkg.
`default_nettype none
module ssad_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire ssad_pkg::lane_t    in_real,
  input  wire ssad_pkg::lane_t    in_ideal,
  input  wire ssad_pkg::shift_t   in_shifts,
  output logic                    done,
  output logic signed [20:0]      angle_delta,
  output logic signed [24:0]      x_shift,
  output logic signed [24:0]      z_shift,
  output logic                    angle_undefined
);
  import ssad_pkg::*;

  localparam logic signed [20:0] ANGLE_LIMIT = 21'sd737280;

  logic signed [ZW:0] diff;
  logic signed [20:0] quot;
  logic signed [20:0] angle_next;

  always_comb begin
    // Half-up rounding: add 128, then arithmetic shift right by 8.
    diff = (ZW+1)'(in_real.z) - (ZW+1)'(in_ideal.z) + (ZW+1)'(128);
    quot = diff[ZW:8];
    if (quot > ANGLE_LIMIT) begin
      angle_next = ANGLE_LIMIT;
    end else if (quot < -ANGLE_LIMIT) begin
      angle_next = -ANGLE_LIMIT;
    end else begin
      angle_next = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    angle_delta     <= angle_next;
    x_shift         <= in_shifts.x_shift;
    z_shift         <= in_shifts.z_shift;
    angle_undefined <= in_real.undef | in_ideal.undef;
  end

`ifndef NO_ASSERTIONS
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> angle_delta <= ANGLE_LIMIT && angle_delta >= -ANGLE_LIMIT)
    else $error("angle_delta outside its saturation limits");
`endif

endmodule
`default_nettype wire

/* rtl/core/strip_survey_alignment_delta_unit.sv */
// Strip survey alignment delta: one request in, one result out.
// Each request passes through two front stages, one register per CORDIC iteration
// and the output register on its way to the done strobe.
// Throughput: one request per cycle; busy is never raised and results need no handshake.
// Reset (rst, synchronous) clears the pipeline valid bits and sets the half sizes to 1024.
`default_nettype none
module strip_survey_alignment_delta_unit #(
  parameter int STRIPS_X         = ssad_pkg::DEF_STRIPS_X,
  parameter int STRIPS_Z         = ssad_pkg::DEF_STRIPS_Z,
  parameter int ANGLE_ITERATIONS = ssad_pkg::DEF_ANGLE_ITERATIONS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [5:0]         strip_col,
  input  wire logic [3:0]         strip_row,
  input  wire logic signed [23:0] real_x1,
  input  wire logic signed [23:0] real_z1,
  input  wire logic signed [23:0] real_x2,
  input  wire logic signed [23:0] real_z2,
  output logic                    done,
  output logic signed [20:0]      angle_delta,
  output logic signed [24:0]      x_shift,
  output logic signed [24:0]      z_shift,
  output logic                    angle_undefined,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import ssad_pkg::*;

  localparam int NSTAGE = (ANGLE_ITERATIONS > MAX_ITERATIONS) ? MAX_ITERATIONS
                                                              : ANGLE_ITERATIONS;
  localparam int LATENCY = NSTAGE + 3;

  logic [15:0] strip_half_x;
  logic [15:0] strip_half_z;
  logic [15:0] cell_half_x;
  logic [15:0] cell_half_z;

  logic [NSTAGE:0] vld;
  lane_t           lane_real  [NSTAGE+1];
  lane_t           lane_ideal [NSTAGE+1];
  shift_t          shifts     [NSTAGE+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_half_x <= HALF_RESET;
      strip_half_z <= HALF_RESET;
      cell_half_x  <= HALF_RESET;
      cell_half_z  <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STRIP_HALF_X: strip_half_x <= cfg_data;
        REG_STRIP_HALF_Z: strip_half_z <= cfg_data;
        REG_CELL_HALF_X:  cell_half_x  <= cfg_data;
        REG_CELL_HALF_Z:  cell_half_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  ssad_front #(
    .STRIPS_X(STRIPS_X),
    .STRIPS_Z(STRIPS_Z)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .strip_col    (strip_col),
    .strip_row    (strip_row),
    .real_x1      (real_x1),
    .real_z1      (real_z1),
    .real_x2      (real_x2),
    .real_z2      (real_z2),
    .strip_half_x (strip_half_x),
    .strip_half_z (strip_half_z),
    .cell_half_x  (cell_half_x),
    .cell_half_z  (cell_half_z),
    .out_valid    (vld[0]),
    .lane_real    (lane_real[0]),
    .lane_ideal   (lane_ideal[0]),
    .shifts       (shifts[0])
  );

  for (genvar g = 0; g < NSTAGE; g++) begin : g_cordic
    ssad_cordic_stage #(
      .STEP(g)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (vld[g]),
      .in_real    (lane_real[g]),
      .in_ideal   (lane_ideal[g]),
      .in_shifts  (shifts[g]),
      .out_valid  (vld[g+1]),
      .out_real   (lane_real[g+1]),
      .out_ideal  (lane_ideal[g+1]),
      .out_shifts (shifts[g+1])
    );
  end

  ssad_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (vld[NSTAGE]),
    .in_real         (lane_real[NSTAGE]),
    .in_ideal        (lane_ideal[NSTAGE]),
    .in_shifts       (shifts[NSTAGE]),
    .done            (done),
    .angle_delta     (angle_delta),
    .x_shift         (x_shift),
    .z_shift         (z_shift),
    .angle_undefined (angle_undefined)
  );

`ifndef NO_ASSERTIONS
  // Every result strobe traces back to an accepted request.
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");
`endif

endmodule
`default_nettype wire
